/* sv/perfect_number_test_defines.svh */
// ----------------------------------------------------------------------------
// Perfect number test assertion macros
// Shared concurrent assertion wrappers for the perfect number test RTL.
// ----------------------------------------------------------------------------
`ifndef PERFECT_NUMBER_TEST_DEFINES_SVH
`define PERFECT_NUMBER_TEST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PNT_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PNT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/pnt_pkg.sv */
// ----------------------------------------------------------------------------
// Perfect number test package
// Fixed field width and the trial-division sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnt_pkg;

    // width of the divisor_sum field on the result word
    localparam int SUM_OUT_WIDTH = 35;

    // trial-division sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_CHECK,
        S_ADD_PARTNER,
        S_DONE
    } search_state_t;

endpackage

`default_nettype wire

/* sv/pnt_in_if.sv */
// ----------------------------------------------------------------------------
// Perfect number test input channel
// Valid/ready channel carrying the number to test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pnt_in_if #(
    parameter int NUMBER_WIDTH = 32
) ();

    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);

endinterface

`default_nettype wire

/* sv/pnt_out_if.sv */
// ----------------------------------------------------------------------------
// Perfect number test result channel
// Valid/ready channel carrying the divisor sum and the perfect flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pnt_out_if ();

    logic                              valid;
    logic                              ready;
    logic [pnt_pkg::SUM_OUT_WIDTH-1:0] divisor_sum;
    logic                              perfect;

    modport source (output valid, output divisor_sum, output perfect, input ready);
    modport sink   (input valid, input divisor_sum, input perfect, output ready);

endinterface

`default_nettype wire

/* sv/pnt_serial_div.sv */
// ----------------------------------------------------------------------------
// Perfect number test serial divider
// Radix-2 restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnt_serial_div #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNTW = $clog2(W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    dvd_reg, dvd_next;   // dividend bits out, quotient bits in
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    dsr_reg, dsr_next;

    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            fits;

    // one restoring step: bring down the next dividend bit, try subtract
    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = ~diff[W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            dvd_next = {dvd_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* sv/pnt_search.sv */
// ----------------------------------------------------------------------------
// Perfect number test divisor search
// Walks trial divisors from 2 while d <= n/d and accumulates divisor pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "perfect_number_test_defines.svh"

module pnt_search #(
    parameter int W = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [W-1:0]                      number,
    output logic                                   idle,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic [pnt_pkg::SUM_OUT_WIDTH-1:0]      divisor_sum,
    output logic                                   perfect
);

    // proper divisor sum stays below 8n
    localparam int SUMW = W + 3;
    localparam logic [W-1:0]    FIRST_TRIAL = W'(2);
    localparam logic [W-1:0]    ONE_N       = W'(1);
    localparam logic [SUMW-1:0] ONE_SUM     = SUMW'(1);

    pnt_pkg::search_state_t state_reg, state_next;

    logic [W-1:0]    n_reg, n_next;
    logic [W-1:0]    d_reg, d_next;
    logic [SUMW-1:0] sum_reg, sum_next;

    // first trial launches in the cycle after acceptance, once n_reg is loaded
    logic            first_launch_reg;

    logic            div_start;
    logic            div_done;
    logic [W-1:0]    quo;
    logic [W-1:0]    rem;

    logic [SUMW+63:0] sum_wide;
    logic [W+63:0]    n_wide;

    pnt_serial_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_next),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // sequencer: next state, datapath updates, divider launch
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sum_next   = sum_reg;
        div_start  = 1'b0;
        idle       = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            pnt_pkg::S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    n_next     = number;
                    d_next     = FIRST_TRIAL;
                    sum_next   = ONE_SUM;
                    state_next = pnt_pkg::S_DIVIDE;
                end
            end
            pnt_pkg::S_DIVIDE:
            begin
                // first launch on entry from idle; n_reg and d_reg are loaded by now
                div_start = first_launch_reg;
                if (div_done)
                    state_next = pnt_pkg::S_CHECK;
            end
            pnt_pkg::S_CHECK:
            begin
                if (quo < d_reg)
                    state_next = pnt_pkg::S_DONE;
                else if (rem == '0)
                begin
                    sum_next = sum_reg + SUMW'(d_reg);
                    if (quo != d_reg)
                        state_next = pnt_pkg::S_ADD_PARTNER;
                    else
                    begin
                        d_next     = d_reg + ONE_N;
                        div_start  = 1'b1;
                        state_next = pnt_pkg::S_DIVIDE;
                    end
                end
                else
                begin
                    d_next     = d_reg + ONE_N;
                    div_start  = 1'b1;
                    state_next = pnt_pkg::S_DIVIDE;
                end
            end
            pnt_pkg::S_ADD_PARTNER:
            begin
                sum_next   = sum_reg + SUMW'(quo);
                d_next     = d_reg + ONE_N;
                div_start  = 1'b1;
                state_next = pnt_pkg::S_DIVIDE;
            end
            pnt_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = pnt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pnt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pnt_pkg::S_IDLE;
            first_launch_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_launch_reg <= (state_reg == pnt_pkg::S_IDLE) && start;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sum_reg <= sum_next;
    end

    // result: sum truncated to the field, perfect compared at 64 bits
    assign sum_wide    = {64'b0, sum_reg};
    assign n_wide      = {64'b0, n_reg};
    assign divisor_sum = sum_wide[pnt_pkg::SUM_OUT_WIDTH-1:0];
    assign perfect     = (n_reg != ONE_N) && (sum_wide[63:0] == n_wide[63:0]);

    // assertions
    `PNT_ASSERT_NOW(a_done_in_divide, clk, rst_n, div_done,
        state_reg == pnt_pkg::S_DIVIDE, "divider finished outside divide state")
    `PNT_ASSERT_NOW(a_trial_floor, clk, rst_n, state_reg == pnt_pkg::S_CHECK,
        d_reg >= FIRST_TRIAL, "trial divisor below two")
    `PNT_ASSERT_NEXT(a_sum_hold, clk, rst_n, state_reg == pnt_pkg::S_DIVIDE,
        $stable(sum_reg), "sum changed while dividing")
    `PNT_ASSERT_NOW(a_partner_after_hit, clk, rst_n, state_reg == pnt_pkg::S_ADD_PARTNER,
        $past(state_reg) == pnt_pkg::S_CHECK && rem == '0,
        "partner add without an exact division")

endmodule

`default_nettype wire

/* sv/perfect_number_test.sv */
// ----------------------------------------------------------------------------
// Perfect number test
// Aliquot sum by trial division with a bit-serial divider.
// ----------------------------------------------------------------------------
// One number is tested at a time. Trial divisors d = 2, 3, ... are tried
// while d <= n/d; each trial runs the serial divider, one quotient bit per
// cycle, then a done step and a check step, plus a partner-add step when
// two distinct divisors of a pair are added. At least one trial always
// runs. The first trial is launched from a register set at acceptance.
// The result is handed to an output register, so the next number is
// accepted while a finished result waits to be taken.
// divisor_sum counts 1 and leaves out n; 0 and 1 both give a sum of 1 and
// are never perfect.
`timescale 1ns / 1ps
`default_nettype none

module perfect_number_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pnt_in_if.sink    item,
    pnt_out_if.source result
);

    logic                              idle;
    logic                              res_valid;
    logic                              res_ready;
    logic [pnt_pkg::SUM_OUT_WIDTH-1:0] sum_res;
    logic                              perfect_res;

    logic                              out_valid_reg, out_valid_next;
    logic [pnt_pkg::SUM_OUT_WIDTH-1:0] sum_out_reg;
    logic                              perfect_out_reg;

    pnt_search #(.W(NUMBER_WIDTH)) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (item.valid && idle),
        .number      (item.number),
        .idle        (idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .divisor_sum (sum_res),
        .perfect     (perfect_res)
    );

    assign item.ready = idle;

    // output register takes a result when empty or being drained
    assign res_ready      = !out_valid_reg || result.ready;
    assign out_valid_next = res_valid ? 1'b1 : (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            sum_out_reg     <= sum_res;
            perfect_out_reg <= perfect_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.divisor_sum = sum_out_reg;
    assign result.perfect     = perfect_out_reg;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Perfect number test testbench
// Sends numbers through the input channel and checks every result word
// against a trial-division predictor of the aliquot sum and the perfect
// flag. Directed words cover zero, one, primes, squares, perfect and
// abundant numbers and the all-ones value. Random words of random bit length
// follow, with random idling on both channels and one long hold on the
// result side that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int NUMBER_WIDTH   = 32;
    localparam int RANDOM_COUNT   = 70;
    localparam int RANDOM_BITS    = 18;
    localparam int HOLD_CYCLES    = 4000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int MAX_REPORTS    = 10;
    // the all-ones word alone runs the longest search in the divider
    localparam int WATCHDOG_LIMIT = 10_000_000;

    // one expected result word
    typedef struct packed {
        logic [NUMBER_WIDTH-1:0]           number;
        logic [pnt_pkg::SUM_OUT_WIDTH-1:0] divisor_sum;
        logic                              perfect;
    } aliquot_result_t;

    logic clk;
    logic rst_n;

    // idling switch shared by both sides, hold request for the result side
    bit idle_on;
    bit hold_request;
    int error_count;

    aliquot_result_t pending_results[$];

    pnt_in_if #(.NUMBER_WIDTH(NUMBER_WIDTH)) in_ch ();
    pnt_out_if                              out_ch ();

    perfect_number_test #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // aliquot sum by trial division, partner counted once on a square
    function automatic aliquot_result_t predict_aliquot(input logic [NUMBER_WIDTH-1:0] n);
        aliquot_result_t  res;
        longint unsigned  value;
        longint unsigned  total;
        longint unsigned  trial;
        longint unsigned  partner;
        value = n;
        total = 1;
        trial = 2;
        while (trial <= value / trial)
        begin
            if (value % trial == 0)
            begin
                partner = value / trial;
                total   = total + trial;
                if (partner != trial)
                    total = total + partner;
            end
            trial = trial + 1;
        end
        res.number      = n;
        res.divisor_sum = total[pnt_pkg::SUM_OUT_WIDTH-1:0];
        res.perfect     = (value != 1) && (value == total);
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    // send one word; called and returning at a rising edge
    task automatic send_number(input logic [NUMBER_WIDTH-1:0] n);
        int gap;
        gap = (idle_on && $urandom_range(99) < 14) ? $urandom_range(6, 1) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.number <= n;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(predict_aliquot(n));
    endtask

    // 0 and 1 both give a sum of 1; 2 and 3 end at the first trial
    task automatic test_trivial_inputs();
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'd2);
        send_number(32'd3);
    endtask

    task automatic test_perfect_numbers();
        send_number(32'd6);
        send_number(32'd28);
        send_number(32'd496);
        send_number(32'd8128);
        send_number(32'd33550336);
    endtask

    // square root divisor must be added once
    task automatic test_square_numbers();
        send_number(32'd4);
        send_number(32'd9);
        send_number(32'd36);
        send_number(32'd10201);
        send_number(32'd65536);
    endtask

    // search runs to the square root with no hit
    task automatic test_prime_numbers();
        send_number(32'd5);
        send_number(32'd97);
        send_number(32'd65521);
        send_number(32'd1048573);
    endtask

    task automatic test_abundant_numbers();
        send_number(32'd12);
        send_number(32'd945);
        send_number(32'd720720);
    endtask

    // every input bit high; longest search of the run
    task automatic test_full_width();
        send_number({NUMBER_WIDTH{1'b1}});
    endtask

    // result side holds off while small words keep coming
    task automatic test_backpressure();
        hold_request <= 1'b1;
        send_number(NUMBER_WIDTH'($urandom_range(255)));
        hold_request <= 1'b0;
        repeat (7)
            send_number(NUMBER_WIDTH'($urandom_range(255)));
    endtask

    // random bit length keeps the searches short; idling off for the first stretch
    task automatic test_random_numbers();
        int                      bits;
        logic [NUMBER_WIDTH-1:0] value;
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            idle_on = (i >= RANDOM_COUNT * 2 / 5);
            bits    = $urandom_range(RANDOM_BITS, 1);
            value   = $urandom_range((32'd1 << bits) - 1, 32'd1 << (bits - 1));
            send_number(value);
        end
    endtask

    // result side: random idling and the long hold
    initial
    begin : result_receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= !(idle_on && $urandom_range(99) < 14);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : result_checker
        aliquot_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf("unexpected word sum=%0d perfect=%0b",
                                       out_ch.divisor_sum, out_ch.perfect));
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.divisor_sum !== want.divisor_sum)
                    log_mismatch($sformatf("n=%0d divisor_sum expected %0d got %0d",
                                           want.number, want.divisor_sum,
                                           out_ch.divisor_sum));
                if (out_ch.perfect !== want.perfect)
                    log_mismatch($sformatf("n=%0d perfect expected %0b got %0b",
                                           want.number, want.perfect, out_ch.perfect));
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // reset, test sequence, drain and verdict
    initial
    begin
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        hold_request <= 1'b0;
        error_count  = 0;
        in_ch.valid  <= 1'b0;
        in_ch.number <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_trivial_inputs();
        test_perfect_numbers();
        test_square_numbers();
        test_prime_numbers();
        test_abundant_numbers();
        test_full_width();
        test_backpressure();
        test_random_numbers();
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
